@@ design/glp_pkg.sv @@
package glp_pkg;

    // Line and token limits
    localparam int LINE_BYTES    = 64;
    localparam int TOKEN_BYTES   = 16;
    localparam int FRACTION_BITS = 16;

    localparam int CNT_W = $clog2(LINE_BYTES);
    localparam int TOK_W = $clog2(TOKEN_BYTES);

    // Keys and key value memory (two banks of eight entries)
    localparam int NUM_KEYS = 8;
    localparam int KEY_W    = 3;
    localparam int MEM_AW   = KEY_W + 1;
    localparam int VAL_W    = 32;

    // Decimal accumulator: magnitude times 10^5, saturated at 2^(31-FRACTION_BITS)
    localparam longint DEC_SCALE   = 100000;
    localparam int     FRAC_DIGITS = 5;
    localparam longint MAG_CAP     = (longint'(1) << (31 - FRACTION_BITS)) * DEC_SCALE;
    localparam int     ACC_W       = $clog2(MAG_CAP + 1);

    // Conversion: q = floor((acc * 2^FB + 50000) / 100000)
    //   = floor((acc * 2^S + 1562) / 3125) with S = FB - 5, split into
    //   acc = 3125*h + r, then q = h * 2^S + floor((r * 2^S + 1562) / 3125)
    localparam int     RED_DIV   = 3125;
    localparam int     SHIFT_S   = FRACTION_BITS - 5;
    localparam int     HALF_RED  = 50000 / 32;
    localparam int     H_W       = ACC_W - 11;
    localparam int     K1        = ACC_W + 11;
    localparam longint RECIP1    = (longint'(1) << K1) / longint'(RED_DIV);
    localparam int     T_W       = SHIFT_S + 12;
    localparam int     K2        = T_W + 12;
    localparam longint RECIP2    = (longint'(1) << K2) / longint'(RED_DIV);
    localparam int     G_W       = SHIFT_S + 1;
    localparam int     Q_W       = H_W + SHIFT_S + 1;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef enum logic [3:0] {
        CMD_INVALID, CMD_HELP, CMD_G28_1, CMD_G28, CMD_G0, CMD_G1, CMD_G2, CMD_G3,
        CMD_G4, CMD_G20, CMD_G21, CMD_G90, CMD_G91, CMD_M2, CMD_M3, CMD_M5
    } t_cmd_kind;

    typedef enum logic [KEY_W-1:0] {
        KEY_X, KEY_Y, KEY_Z, KEY_F, KEY_I, KEY_J, KEY_P, KEY_S
    } t_key;

    typedef enum logic [1:0] {TK_SKIP, TK_TOKEN, TK_DONE} t_tok_phase;

    typedef enum logic [1:0] {NP_IDLE, NP_SPACE, NP_INT, NP_FRAC} t_num_phase;

    typedef enum logic [1:0] {EM_IDLE, EM_DRAIN, EM_READ} t_em_state;

    typedef struct packed {
        logic       hit;
        t_key       key;
    } t_key_hit;

    // Command words, right aligned, first character in the top used byte
    localparam int CMD_COUNT  = 22;
    localparam int CMD_WORD_W = 40;

    typedef struct packed {
        logic [CMD_WORD_W-1:0] word;
        logic [2:0]            len;
        t_cmd_kind             kind;
    } t_cmd_entry;

    localparam t_cmd_entry CMD_TABLE [CMD_COUNT] = '{
        '{CMD_WORD_W'("H"),     3'd1, CMD_HELP},
        '{CMD_WORD_W'("HELP"),  3'd4, CMD_HELP},
        '{CMD_WORD_W'("G28.1"), 3'd5, CMD_G28_1},
        '{CMD_WORD_W'("G28"),   3'd3, CMD_G28},
        '{CMD_WORD_W'("G0"),    3'd2, CMD_G0},
        '{CMD_WORD_W'("G00"),   3'd3, CMD_G0},
        '{CMD_WORD_W'("G1"),    3'd2, CMD_G1},
        '{CMD_WORD_W'("G01"),   3'd3, CMD_G1},
        '{CMD_WORD_W'("G2"),    3'd2, CMD_G2},
        '{CMD_WORD_W'("G02"),   3'd3, CMD_G2},
        '{CMD_WORD_W'("G3"),    3'd2, CMD_G3},
        '{CMD_WORD_W'("G03"),   3'd3, CMD_G3},
        '{CMD_WORD_W'("G4"),    3'd2, CMD_G4},
        '{CMD_WORD_W'("G04"),   3'd3, CMD_G4},
        '{CMD_WORD_W'("G20"),   3'd3, CMD_G20},
        '{CMD_WORD_W'("G21"),   3'd3, CMD_G21},
        '{CMD_WORD_W'("G90"),   3'd3, CMD_G90},
        '{CMD_WORD_W'("G91"),   3'd3, CMD_G91},
        '{CMD_WORD_W'("M2"),    3'd2, CMD_M2},
        '{CMD_WORD_W'("M02"),   3'd3, CMD_M2},
        '{CMD_WORD_W'("M3"),    3'd2, CMD_M3},
        '{CMD_WORD_W'("M5"),    3'd2, CMD_M5}
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_key_hit key_lookup(input logic [7:0] c);
        t_key_hit r;
        r.hit = 1'b1;
        r.key = KEY_X;
        unique case (c)
            "X":     r.key = KEY_X;
            "Y":     r.key = KEY_Y;
            "Z":     r.key = KEY_Z;
            "F":     r.key = KEY_F;
            "I":     r.key = KEY_I;
            "J":     r.key = KEY_J;
            "P":     r.key = KEY_P;
            "S":     r.key = KEY_S;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // Character of a command word at a position inside the word
    function automatic logic [7:0] cmd_byte(input t_cmd_entry e, input logic [2:0] pos);
        logic [2:0] idx;
        idx = e.len - 3'd1 - pos;
        return e.word[8*idx +: 8];
    endfunction

    // Weight of a fraction digit in units of 10^-5
    function automatic logic [13:0] frac_weight(input logic [2:0] n);
        logic [13:0] w;
        unique case (n)
            3'd0:    w = 14'd10000;
            3'd1:    w = 14'd1000;
            3'd2:    w = 14'd100;
            3'd3:    w = 14'd10;
            default: w = 14'd1;
        endcase
        return w;
    endfunction

endpackage

@@ design/gcode_line_parser.sv @@
// G-code line parser.
// Input channel: i_valid / o_stall carry one character per beat (i_character).
// A NUL character ends the line. Only the first LINE_BYTES-1 characters count.
// Output channel: o_valid / i_stall carry one key result per beat. A recognized
// command gives eight beats (keys X,Y,Z,F,I,J,P,S), an unrecognized one a single
// beat that is zero but for o_last; o_last marks the final beat of a line.
// Throughput: one character per cycle, sustained, also while the results of
// the previous line are still being sent. A line end is held off (o_stall)
// only while the results of the line before are not all read out.
// Results: after the NUL beat the emitter waits until no conversion of the line
// is left in the pipeline; each key value goes through a four stage
// reciprocal-multiply pipeline before it is written to the key value memory
// (two banks, one per line in flight). Results then stream at one beat per
// cycle while the receiver does not stall, through a registered memory read
// and the output register.
// Reset (synchronous, active low) clears the line state, the pipeline valids and
// the output register; no results are pending afterwards.
// When the receiver stalls, the output beat holds and one more read result
// waits behind it; further reads pause until the output register drains.
module gcode_line_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_character,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [3:0]                 o_command_type,
    output logic                       o_recognized,
    output logic [glp_pkg::KEY_W-1:0]  o_key_index,
    output logic                       o_present,
    output logic signed [glp_pkg::VAL_W-1:0] o_value,
    output logic                       o_last
);
    import glp_pkg::*;

    // ------------------------------------------------------------------
    // Line state
    logic [CNT_W-1:0]     r_count, n_count;
    t_tok_phase           r_tok_ph, n_tok_ph;
    logic [TOK_W-1:0]     r_tok_len, n_tok_len;
    logic [CMD_COUNT-1:0] r_cand, n_cand;
    logic [NUM_KEYS-1:0]  r_present, n_present;
    t_num_phase           r_num, n_num;
    t_key                 r_key, n_key;
    logic                 r_neg, n_neg;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [2:0]           r_fdc, n_fdc;
    logic                 r_bank;

    logic                 in_fire;
    logic                 line_end;
    logic                 push;
    logic [7:0]           uc;
    logic                 digit;
    logic                 consumed;
    t_key_hit             khit;
    logic [ACC_W+3:0]     int_sum;
    logic [ACC_W:0]       frac_sum;
    logic [ACC_W-1:0]     int_acc;
    logic [ACC_W-1:0]     frac_acc;
    t_cmd_kind            cmd_match;

    // ------------------------------------------------------------------
    // Conversion pipeline
    logic                 r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic [2*ACC_W-1:0]   r_s1_prod;
    logic [ACC_W-1:0]     r_s1_acc;
    logic                 r_s1_neg, r_s2_neg, r_s3_neg, r_s4_neg;
    t_key                 r_s1_key, r_s2_key, r_s3_key, r_s4_key;
    logic                 r_s1_bank, r_s2_bank, r_s3_bank, r_s4_bank;
    logic [H_W-1:0]       r_s2_h, r_s3_h;
    logic [11:0]          r_s2_r;
    logic [T_W-1:0]       r_s3_t;
    logic [2*T_W:0]       r_s3_prod;
    logic [Q_W-1:0]       r_s4_q;

    logic [H_W-1:0]       s2_h0;
    logic [ACC_W-1:0]     s2_rem_full;
    logic [12:0]          s2_rem;
    logic [H_W-1:0]       s2_h;
    logic [11:0]          s2_r;
    logic [T_W-1:0]       s3_t;
    logic [G_W-1:0]       s4_g0;
    logic [T_W-1:0]       s4_rem_full;
    logic [12:0]          s4_rem;
    logic [G_W-1:0]       s4_g;
    logic [Q_W-1:0]       s4_q;
    logic [Q_W-1:0]       wr_mag;
    logic [VAL_W-1:0]     wr_value;

    // Key value memory, one bank per line
    logic [VAL_W-1:0]     r_mem [2*NUM_KEYS];
    logic [VAL_W-1:0]     r_mem_q;

    // ------------------------------------------------------------------
    // Result emitter
    t_em_state            r_em_state, n_em_state;
    logic                 r_em_bank;
    t_cmd_kind            r_em_kind;
    logic [NUM_KEYS-1:0]  r_em_present;
    t_key                 r_em_key;
    logic                 pending;
    logic                 rd_issue;
    logic                 rd_last;

    logic                 r_rd_valid;
    t_cmd_kind            r_rd_kind;
    t_key                 r_rd_key;
    logic                 r_rd_present;
    logic                 r_rd_last;
    logic                 out_load;

    logic                 r_out_valid;
    t_cmd_kind            r_out_kind;
    logic                 r_out_recognized;
    t_key                 r_out_key;
    logic                 r_out_present;
    logic [VAL_W-1:0]     r_out_value;
    logic                 r_out_last;

    // ------------------------------------------------------------------
    // Input handshake: a line end waits while the emitter is busy
    assign o_stall  = (r_em_state != EM_IDLE) && (i_character == CH_NUL);
    assign in_fire  = i_valid && !o_stall;
    assign line_end = in_fire && (i_character == CH_NUL);

    // Command match on the collected token
    always_comb begin
        cmd_match = CMD_INVALID;
        for (int i = 0; i < CMD_COUNT; i++) begin
            if (r_cand[i] && (TOK_W'(CMD_TABLE[i].len) == r_tok_len)) begin
                cmd_match = CMD_TABLE[i].kind;
            end
        end
    end

    // Digit arithmetic on the accumulator
    always_comb begin
        uc = i_character;
        if (i_character >= CH_LOW_A && i_character <= CH_LOW_Z) begin
            uc = i_character - CASE_OFS;
        end
        digit    = (uc >= CH_ZERO) && (uc <= CH_NINE);
        khit     = key_lookup(uc);
        int_sum  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                 + (ACC_W+4)'(uc[3:0]) * (ACC_W+4)'(DEC_SCALE);
        int_acc  = (int_sum > (ACC_W+4)'(MAG_CAP)) ? ACC_W'(MAG_CAP) : int_sum[ACC_W-1:0];
        frac_sum = {1'b0, r_acc} + (ACC_W+1)'(uc[3:0]) * (ACC_W+1)'(frac_weight(r_fdc));
        frac_acc = (frac_sum > (ACC_W+1)'(MAG_CAP)) ? ACC_W'(MAG_CAP) : frac_sum[ACC_W-1:0];
    end

    // Per-character line state update
    always_comb begin
        n_count   = r_count;
        n_tok_ph  = r_tok_ph;
        n_tok_len = r_tok_len;
        n_cand    = r_cand;
        n_present = r_present;
        n_num     = r_num;
        n_key     = r_key;
        n_neg     = r_neg;
        n_acc     = r_acc;
        n_fdc     = r_fdc;
        push      = 1'b0;
        consumed  = 1'b0;

        if (line_end) begin
            // close any running number, then start a fresh line
            push      = (r_num != NP_IDLE);
            n_count   = '0;
            n_tok_ph  = TK_SKIP;
            n_tok_len = '0;
            n_cand    = '1;
            n_present = '0;
            n_num     = NP_IDLE;
            n_key     = KEY_X;
            n_neg     = 1'b0;
            n_acc     = '0;
            n_fdc     = '0;
        end else if (in_fire && (r_count < CNT_W'(LINE_BYTES - 1))) begin
            n_count = r_count + CNT_W'(1);

            // command token
            if (r_tok_ph == TK_SKIP && !is_space(uc)) begin
                n_tok_ph = TK_TOKEN;
            end
            if (n_tok_ph == TK_TOKEN) begin
                if (is_space(uc)) begin
                    n_tok_ph = TK_DONE;
                end else if (r_tok_len < TOK_W'(TOKEN_BYTES - 1)) begin
                    n_tok_len = r_tok_len + TOK_W'(1);
                    for (int i = 0; i < CMD_COUNT; i++) begin
                        n_cand[i] = r_cand[i]
                                  && (r_tok_len < TOK_W'(CMD_TABLE[i].len))
                                  && (cmd_byte(CMD_TABLE[i], r_tok_len[2:0]) == uc);
                    end
                end
            end

            // number after a key
            unique case (r_num)
                NP_IDLE: begin
                    consumed = 1'b0;
                end
                NP_SPACE: begin
                    if (is_space(uc)) begin
                        consumed = 1'b1;
                    end else if (uc == CH_PLUS || uc == CH_MINUS) begin
                        consumed = 1'b1;
                        n_neg    = (uc == CH_MINUS);
                        n_num    = NP_INT;
                    end else if (digit) begin
                        consumed = 1'b1;
                        n_acc    = int_acc;
                        n_num    = NP_INT;
                    end else if (uc == CH_POINT) begin
                        consumed = 1'b1;
                        n_num    = NP_FRAC;
                    end
                end
                NP_INT: begin
                    if (digit) begin
                        consumed = 1'b1;
                        n_acc    = int_acc;
                    end else if (uc == CH_POINT) begin
                        consumed = 1'b1;
                        n_num    = NP_FRAC;
                    end
                end
                NP_FRAC: begin
                    if (digit) begin
                        consumed = 1'b1;
                        if (r_fdc < 3'(FRAC_DIGITS)) begin
                            n_acc = frac_acc;
                            n_fdc = r_fdc + 3'd1;
                        end
                    end
                end
            endcase

            // anything else ends the number; a new key starts one
            if (!consumed) begin
                push  = (r_num != NP_IDLE);
                n_num = NP_IDLE;
                if (khit.hit && !r_present[khit.key]) begin
                    n_present[khit.key] = 1'b1;
                    n_key = khit.key;
                    n_num = NP_SPACE;
                    n_neg = 1'b0;
                    n_acc = '0;
                    n_fdc = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_tok_ph  <= TK_SKIP;
            r_tok_len <= '0;
            r_cand    <= '1;
            r_present <= '0;
            r_num     <= NP_IDLE;
            r_key     <= KEY_X;
            r_neg     <= 1'b0;
            r_acc     <= '0;
            r_fdc     <= '0;
            r_bank    <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_tok_ph  <= n_tok_ph;
            r_tok_len <= n_tok_len;
            r_cand    <= n_cand;
            r_present <= n_present;
            r_num     <= n_num;
            r_key     <= n_key;
            r_neg     <= n_neg;
            r_acc     <= n_acc;
            r_fdc     <= n_fdc;
            if (line_end) begin
                r_bank <= ~r_bank;
            end
        end
    end

    // ------------------------------------------------------------------
    // Conversion pipeline: valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= push;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    // Stage 2: h = acc / 3125 by reciprocal, with one correction step
    always_comb begin
        s2_h0       = r_s1_prod[2*ACC_W-1:K1];
        s2_rem_full = r_s1_acc - ACC_W'(s2_h0) * ACC_W'(RED_DIV);
        s2_rem      = s2_rem_full[12:0];
        if (s2_rem >= 13'(RED_DIV)) begin
            s2_h = s2_h0 + H_W'(1);
            s2_r = 12'(s2_rem - 13'(RED_DIV));
        end else begin
            s2_h = s2_h0;
            s2_r = s2_rem[11:0];
        end
    end

    // Stage 3 operand: remainder scaled and rounded
    assign s3_t = (T_W'(r_s2_r) << SHIFT_S) + T_W'(HALF_RED);

    // Stage 4: g = t / 3125 by reciprocal, then q = h * 2^S + g
    always_comb begin
        s4_g0       = r_s3_prod[2*T_W:K2];
        s4_rem_full = r_s3_t - T_W'(s4_g0) * T_W'(RED_DIV);
        s4_rem      = s4_rem_full[12:0];
        s4_g        = (s4_rem >= 13'(RED_DIV)) ? s4_g0 + G_W'(1) : s4_g0;
        s4_q        = (Q_W'(r_s3_h) << SHIFT_S) + Q_W'(s4_g);
    end

    // Conversion pipeline: payload
    always_ff @(posedge i_clk) begin
        r_s1_prod <= (2*ACC_W)'(r_acc) * (2*ACC_W)'(RECIP1);
        r_s1_acc  <= r_acc;
        r_s1_neg  <= r_neg;
        r_s1_key  <= r_key;
        r_s1_bank <= r_bank;

        r_s2_h    <= s2_h;
        r_s2_r    <= s2_r;
        r_s2_neg  <= r_s1_neg;
        r_s2_key  <= r_s1_key;
        r_s2_bank <= r_s1_bank;

        r_s3_t    <= s3_t;
        r_s3_prod <= (2*T_W+1)'(s3_t) * (2*T_W+1)'(RECIP2);
        r_s3_h    <= r_s2_h;
        r_s3_neg  <= r_s2_neg;
        r_s3_key  <= r_s2_key;
        r_s3_bank <= r_s2_bank;

        r_s4_q    <= s4_q;
        r_s4_neg  <= r_s3_neg;
        r_s4_key  <= r_s3_key;
        r_s4_bank <= r_s3_bank;
    end

    // Saturate and apply the sign
    always_comb begin
        if (r_s4_neg) begin
            wr_mag   = (r_s4_q > Q_W'(64'h8000_0000)) ? Q_W'(64'h8000_0000) : r_s4_q;
            wr_value = VAL_W'(0) - wr_mag[VAL_W-1:0];
        end else begin
            wr_mag   = (r_s4_q > Q_W'(64'h7FFF_FFFF)) ? Q_W'(64'h7FFF_FFFF) : r_s4_q;
            wr_value = wr_mag[VAL_W-1:0];
        end
    end

    // Key value memory: pipeline writes, emitter reads
    always_ff @(posedge i_clk) begin
        if (r_s4_valid) begin
            r_mem[{r_s4_bank, r_s4_key}] <= wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_mem_q <= r_mem[{r_em_bank, r_em_key}];
        end
    end

    // ------------------------------------------------------------------
    // Emitter: wait for the line's conversions to land, then read out
    assign pending = (r_s1_valid && r_s1_bank == r_em_bank)
                  || (r_s2_valid && r_s2_bank == r_em_bank)
                  || (r_s3_valid && r_s3_bank == r_em_bank)
                  || (r_s4_valid && r_s4_bank == r_em_bank);

    always_comb begin
        n_em_state = r_em_state;
        unique case (r_em_state)
            EM_IDLE:  if (line_end) n_em_state = EM_DRAIN;
            EM_DRAIN: if (!pending) n_em_state = EM_READ;
            EM_READ:  if (rd_issue && rd_last) n_em_state = EM_IDLE;
            default:  n_em_state = EM_IDLE;
        endcase
    end

    always_comb begin
        rd_issue = (r_em_state == EM_READ) && (!r_rd_valid || out_load);
        rd_last  = (r_em_kind == CMD_INVALID) || (r_em_key == KEY_S);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_state <= EM_IDLE;
            r_em_key   <= KEY_X;
        end else begin
            r_em_state <= n_em_state;
            if (line_end) begin
                r_em_key <= KEY_X;
            end else if (rd_issue) begin
                r_em_key <= t_key'(r_em_key + KEY_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (line_end) begin
            r_em_bank    <= r_bank;
            r_em_kind    <= cmd_match;
            r_em_present <= r_present;
        end
    end

    // Read stage and output register
    assign out_load = r_rd_valid && (!r_out_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_issue) begin
                r_rd_valid <= 1'b1;
            end else if (out_load) begin
                r_rd_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_kind    <= r_em_kind;
            r_rd_key     <= r_em_key;
            r_rd_present <= (r_em_kind != CMD_INVALID) && r_em_present[r_em_key];
            r_rd_last    <= rd_last;
        end
        if (out_load) begin
            r_out_kind       <= r_rd_kind;
            r_out_recognized <= (r_rd_kind != CMD_INVALID);
            r_out_key        <= r_rd_key;
            r_out_present    <= r_rd_present;
            r_out_value      <= r_rd_present ? r_mem_q : '0;
            r_out_last       <= r_rd_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_command_type = r_out_kind;
    assign o_recognized   = r_out_recognized;
    assign o_key_index    = r_out_key;
    assign o_present      = r_out_present;
    assign o_value        = r_out_value;
    assign o_last         = r_out_last;

endmodule

@@ sim/gcode_line_parser_tb.sv @@
module gcode_line_parser_tb;

    import glp_pkg::*;

    // Cycles without any accepted beat before the run is declared hung
    localparam int IDLE_LIMIT = 2000;
    // Length of the one long receiver hold-off
    localparam int HOLD_CYCLES = 80;

    // One key result as it leaves the block
    typedef struct packed {
        t_cmd_kind          cmd;
        logic               rec;
        logic [KEY_W-1:0]   key;
        logic               pres;
        logic [VAL_W-1:0]   val;
        logic               last;
    } key_result_t;

    // Line parser prediction and the queue of key results still owed by the block
    class line_scoreboard;
        key_result_t    pending_results[$];
        int             errors;

        // Parser state; the counters use the block's widths
        logic [CNT_W-1:0]       n_chars;
        t_tok_phase             tok_ph;
        logic [8*15-1:0]        tok;
        logic [TOK_W-1:0]       tok_len;
        logic [NUM_KEYS-1:0]    seen;
        logic [VAL_W-1:0]       vals[NUM_KEYS];
        t_num_phase             num_ph;
        t_key                   cur_key;
        logic                   neg;
        logic [33:0]            acc;
        logic [2:0]             n_frac;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            n_chars = '0;
            tok_ph  = TK_SKIP;
            tok     = '0;
            tok_len = '0;
            seen    = '0;
            foreach (vals[k]) vals[k] = '0;
            num_ph  = NP_IDLE;
            cur_key = KEY_X;
            neg     = 1'b0;
            acc     = '0;
            n_frac  = '0;
        endfunction

        function bit blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        // Key slot of a letter, NUM_KEYS when it is no key
        function int key_slot(logic [7:0] c);
            case (c)
                "X":     return int'(KEY_X);
                "Y":     return int'(KEY_Y);
                "Z":     return int'(KEY_Z);
                "F":     return int'(KEY_F);
                "I":     return int'(KEY_I);
                "J":     return int'(KEY_J);
                "P":     return int'(KEY_P);
                "S":     return int'(KEY_S);
                default: return NUM_KEYS;
            endcase
        endfunction

        // Token is zero padded on the left, so its low five bytes identify it
        function t_cmd_kind decode_cmd();
            if (tok_len > 5)
                return CMD_INVALID;
            case (tok[39:0])
                "H", "HELP":  return CMD_HELP;
                "G28.1":      return CMD_G28_1;
                "G28":        return CMD_G28;
                "G0", "G00":  return CMD_G0;
                "G1", "G01":  return CMD_G1;
                "G2", "G02":  return CMD_G2;
                "G3", "G03":  return CMD_G3;
                "G4", "G04":  return CMD_G4;
                "G20":        return CMD_G20;
                "G21":        return CMD_G21;
                "G90":        return CMD_G90;
                "G91":        return CMD_G91;
                "M2", "M02":  return CMD_M2;
                "M3":         return CMD_M3;
                "M5":         return CMD_M5;
                default:      return CMD_INVALID;
            endcase
        endfunction

        // Decimal magnitude (units of 1e-5) to rounded, saturated Q16.16
        function logic [VAL_W-1:0] fixed_value();
            logic [63:0] q;
            q = (({30'd0, acc} << FRACTION_BITS) + 64'(DEC_SCALE / 2)) / 64'(DEC_SCALE);
            if (neg) begin
                if (q > 64'h8000_0000)
                    q = 64'h8000_0000;
                return 32'd0 - q[31:0];
            end
            if (q > 64'h7FFF_FFFF)
                q = 64'h7FFF_FFFF;
            return q[31:0];
        endfunction

        function void add_int(logic [7:0] c);
            logic [63:0] a;
            a = {30'd0, acc} * 64'd10 + 64'(c - CH_ZERO) * 64'(DEC_SCALE);
            acc = (a > 64'(MAG_CAP)) ? 34'(MAG_CAP) : a[33:0];
        endfunction

        function void add_frac(logic [7:0] c);
            logic [63:0] a;
            logic [63:0] w;
            if (n_frac >= 3'(FRAC_DIGITS))
                return;
            case (n_frac)
                3'd0:    w = 64'd10000;
                3'd1:    w = 64'd1000;
                3'd2:    w = 64'd100;
                3'd3:    w = 64'd10;
                default: w = 64'd1;
            endcase
            a = {30'd0, acc} + 64'(c - CH_ZERO) * w;
            acc = (a > 64'(MAG_CAP)) ? 34'(MAG_CAP) : a[33:0];
            n_frac = n_frac + 3'd1;
        endfunction

        // Returns 1 when the character belongs to the running number
        function bit number_takes(logic [7:0] c);
            bit digit;
            digit = c >= CH_ZERO && c <= CH_NINE;
            case (num_ph)
                NP_SPACE: begin
                    if (blank(c))
                        return 1;
                    if (c == CH_PLUS || c == CH_MINUS) begin
                        neg = (c == CH_MINUS);
                        num_ph = NP_INT;
                        return 1;
                    end
                    if (digit) begin
                        add_int(c);
                        num_ph = NP_INT;
                        return 1;
                    end
                    if (c == CH_POINT) begin
                        num_ph = NP_FRAC;
                        return 1;
                    end
                    return 0;
                end
                NP_INT: begin
                    if (digit) begin
                        add_int(c);
                        return 1;
                    end
                    if (c == CH_POINT) begin
                        num_ph = NP_FRAC;
                        return 1;
                    end
                    return 0;
                end
                NP_FRAC: begin
                    if (digit) begin
                        add_frac(c);
                        return 1;
                    end
                    return 0;
                end
                default: return 0;
            endcase
        endfunction

        function void close_number();
            if (num_ph == NP_IDLE)
                return;
            vals[cur_key] = fixed_value();
            num_ph = NP_IDLE;
        endfunction

        // Accepted input beat: advance the line state, queue results at NUL
        function void take_char(logic [7:0] c);
            key_result_t r;
            t_cmd_kind   kind;
            int          k;
            if (c == CH_NUL) begin
                close_number();
                kind = decode_cmd();
                if (kind == CMD_INVALID) begin
                    r = '0;
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end else begin
                    for (k = 0; k < NUM_KEYS; k++) begin
                        r.cmd  = kind;
                        r.rec  = 1'b1;
                        r.key  = KEY_W'(k);
                        r.pres = seen[k];
                        r.val  = seen[k] ? vals[k] : '0;
                        r.last = (k == NUM_KEYS - 1);
                        pending_results.push_back(r);
                    end
                end
                clear_line();
                return;
            end
            // Bytes past the counted part of the line are dropped
            if (n_chars >= CNT_W'(LINE_BYTES - 1))
                return;
            n_chars = n_chars + 1'b1;
            if (c >= CH_LOW_A && c <= CH_LOW_Z)
                c = c - CASE_OFS;
            // Command token
            if (tok_ph == TK_SKIP && !blank(c))
                tok_ph = TK_TOKEN;
            if (tok_ph == TK_TOKEN) begin
                if (blank(c))
                    tok_ph = TK_DONE;
                else if (tok_len < TOK_W'(TOKEN_BYTES - 1)) begin
                    tok = {tok[8*14-1:0], c};
                    tok_len = tok_len + 1'b1;
                end
            end
            if (number_takes(c))
                return;
            close_number();
            // First occurrence of a key opens its number
            k = key_slot(c);
            if (k < NUM_KEYS && !seen[k]) begin
                seen[k] = 1'b1;
                cur_key = t_key'(k);
                num_ph  = NP_SPACE;
                neg     = 1'b0;
                acc     = '0;
                n_frac  = '0;
            end
        endfunction

        task report(string what, longint got, longint want);
            if (errors < 20)
                $display("mismatch: %s got %0h expected %0h", what, got, want);
            errors++;
        endtask

        // Accepted output beat against the oldest expectation
        task check_result(key_result_t got);
            key_result_t want;
            if (pending_results.size() == 0) begin
                report("result with none expected, value", got.val, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.cmd !== want.cmd)   report("command_type", got.cmd, want.cmd);
            if (got.rec !== want.rec)   report("recognized", got.rec, want.rec);
            if (got.key !== want.key)   report("key_index", got.key, want.key);
            if (got.pres !== want.pres) report("present", got.pres, want.pres);
            if (got.val !== want.val)   report("value", got.val, want.val);
            if (got.last !== want.last) report("last", got.last, want.last);
        endtask
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [7:0]                 i_character;
    logic                       o_valid;
    logic                       i_stall;
    logic [3:0]                 o_command_type;
    logic                       o_recognized;
    logic [KEY_W-1:0]           o_key_index;
    logic                       o_present;
    logic signed [VAL_W-1:0]    o_value;
    logic                       o_last;

    line_scoreboard sb = new();

    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int chars_sent;
    int quiet_cycles;

    string cmd_words[22] = '{"H", "HELP", "G28.1", "G28", "G0", "G00", "G1", "G01",
                             "G2", "G02", "G3", "G03", "G4", "G04", "G20", "G21",
                             "G90", "G91", "M2", "M02", "M3", "M5"};

    gcode_line_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_character    (i_character),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_command_type (o_command_type),
        .o_recognized   (o_recognized),
        .o_key_index    (o_key_index),
        .o_present      (o_present),
        .o_value        (o_value),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitors: sample both channels at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.take_char(i_character);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_command_type, o_recognized, o_key_index,
                             o_present, o_value, o_last});
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall bursts plus one long hold-off
    initial begin : receiver
        bit hold_done;
        hold_done = 0;
        i_stall <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one character and wait for its beat
    task automatic send_char(input logic [7:0] c);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= c;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
    endtask

    // Send text, optionally lower-casing some letters
    task automatic send_text(input string s, input bit mix_case);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "A" && c <= "Z" && $urandom_range(0, 2) == 0)
                c = c + CASE_OFS;
            send_char(c);
        end
    endtask

    task automatic end_line();
        send_char(CH_NUL);
    endtask

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 4) == 0)
            return CH_TAB + 8'($urandom_range(0, 4));
        return CH_SPACE;
    endfunction

    function automatic logic [7:0] digit_char();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Random line: mostly well-formed commands with keys, some noise and broken tokens
    task automatic random_line();
        string keys = "XYZFIJPS";
        string syms = "GMH0123458.9";
        string fill = " 9.-XS";
        int    kind;
        int    sign;
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            repeat ($urandom_range(0, 20)) send_char(8'($urandom_range(1, 255)));
        end else begin
            if ($urandom_range(0, 3) == 0)
                send_char(blank_char());
            if (kind < 8)
                send_text(cmd_words[$urandom_range(0, 21)], 1);
            else
                repeat ($urandom_range(1, 18))
                    send_char(syms[$urandom_range(0, syms.len() - 1)]);
            repeat ($urandom_range(0, 5)) begin
                send_char(blank_char());
                send_text(string'(keys[$urandom_range(0, 7)]), 1);
                if ($urandom_range(0, 4) == 0)
                    send_char(blank_char());
                sign = $urandom_range(0, 3);
                if (sign == 0)
                    send_char(CH_PLUS);
                else if (sign == 1)
                    send_char(CH_MINUS);
                repeat ($urandom_range(0, 6)) send_char(digit_char());
                if ($urandom_range(0, 1)) begin
                    send_char(CH_POINT);
                    repeat ($urandom_range(0, 7)) send_char(digit_char());
                end
            end
            if ($urandom_range(0, 7) == 0)
                send_text(" e5*X", 1);
            // Occasionally run past the counted part of the line
            if ($urandom_range(0, 15) == 0)
                repeat (60) send_char(fill[$urandom_range(0, fill.len() - 1)]);
        end
        end_line();
    endtask

    initial begin : stimulus
        int rand_start;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_character <= CH_NUL;
        tx_idle  = 1;
        rx_idle  = 1;
        hold_req = 0;
        chars_sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines
        end_line();
        send_text("help 5", 0);             end_line();
        send_text("G28.1 X-0.5 Y+2.25", 0); end_line();
        send_text("G28 Z F", 0);            end_line();
        send_text("G0 X1 Y2 Z3 F4 I5 J6 P7 S8", 0); end_line();
        send_text("G00 X-32768 Y32767.99999 Z99999 F-99999.5 I-32767.99999", 0);
        end_line();
        send_text("G1 X0.000004 Y0.00001 Z0.123456789 F0.000005", 0); end_line();
        send_text("G01 X.5 Y-.25 Z- 3 F 7 I+ J.", 0); end_line();
        send_text("G2 X1E5 I-3", 0);        end_line();
        send_text("G02 X1X2 Y3Y4 Z-1Z", 0); end_line();
        // Every whitespace code around token and number
        send_char(CH_TAB);
        send_char(8'h0B);
        send_text("G3", 0);
        send_char(8'h0C);
        send_text(" X", 0);
        send_char(CH_CR);
        send_text("-1.5", 0);
        send_char(8'h0A);
        end_line();
        // High-bit and control bytes
        send_text("M5 ", 0);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);
        send_text("S-1", 0);
        end_line();
        send_text("G28.", 0);               end_line();
        send_text("M3S200", 0);             end_line();
        send_text("G0000000000000000000 X1", 0); end_line();
        // Key letter and its digit on the last counted bytes, then bytes that no longer count
        send_text("G1 X1", 0);
        repeat (56) send_char(CH_SPACE);
        send_text("Y2 S3 Z4", 0);
        end_line();
        foreach (cmd_words[i]) begin
            send_text(cmd_words[i], 1);
            send_text(" S-", 0);
            send_char(CH_ZERO + 8'(i % 10));
            end_line();
        end

        // Random lines; one long receiver hold-off, no idling at the end
        rand_start = chars_sent;
        while (chars_sent < rand_start + 300) begin
            if (chars_sent > rand_start + 60)
                hold_req = 1;
            if (chars_sent > rand_start + 220) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            random_line();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report("results never delivered, count", sb.pending_results.size(), 0);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
design/glp_pkg.sv
design/gcode_line_parser.sv
sim/gcode_line_parser_tb.sv
